@@ hdl/lcrgb_pkg.sv @@
`default_nettype none

package lcrgb_pkg;

  localparam int IN_W  = 18;
  localparam int CH_W  = IN_W + 1;
  localparam int PIX_W = 16;
  localparam int RES_W = 25;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MAX  = 1'd1;

  localparam logic MODE_YCBCR = 1'b0;
  localparam logic MODE_YCOCG = 1'b1;

  localparam logic [PIX_W-1:0] PIXEL_MAX_RESET = 16'd1023;

  typedef logic signed [RES_W-1:0] res_t;
  typedef logic [PIX_W-1:0]        pix_t;

endpackage

`default_nettype wire

@@ hdl/lcrgb_clip.sv @@
`default_nettype none

module lcrgb_clip (
  input  wire lcrgb_pkg::res_t value,
  input  wire lcrgb_pkg::pix_t pixel_max,
  output lcrgb_pkg::pix_t      clipped
);
  import lcrgb_pkg::*;

  logic signed [RES_W-1:0] limit;

  assign limit = $signed({{(RES_W-PIX_W){1'b0}}, pixel_max});

  always_comb begin
    priority if (value < 0) begin
      clipped = '0;
    end else if (value > limit) begin
      clipped = pixel_max;
    end else begin
      clipped = value[PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/luma_chroma_to_rgb_convert_core.sv @@
`default_nettype none
// Luma/chroma to RGB converter, five register stages.
// Throughput: one item per cycle; each stage holds only while the next is full and stalled.
// Stages: offset removal, coefficient multiply, sum, round, clip.
// In YCoCg mode stages 2 to 4 run lifting steps in place of the matrix and rounding.
// Reset: valid bits clear, color_mode returns to 0 and pixel_max to 1023.

module luma_chroma_to_rgb_convert_core #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [lcrgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lcrgb_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  signed [lcrgb_pkg::IN_W-1:0]    luma,
  input  wire  signed [lcrgb_pkg::IN_W-1:0]    chroma_first,
  input  wire  signed [lcrgb_pkg::IN_W-1:0]    chroma_second,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [lcrgb_pkg::PIX_W-1:0]          red,
  output logic [lcrgb_pkg::PIX_W-1:0]          green,
  output logic [lcrgb_pkg::PIX_W-1:0]          blue
);
  import lcrgb_pkg::*;

  localparam int KW = COEF_FRAC_BITS + 2;
  localparam int PW = KW + CH_W;
  localparam int AW = COEF_FRAC_BITS + RES_W - 1;

  localparam logic signed [KW-1:0] K_RCR =
    KW'(((64'd14020 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [KW-1:0] K_GCB =
    KW'(((64'd34413 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic signed [KW-1:0] K_GCR =
    KW'(((64'd71414 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic signed [KW-1:0] K_BCB =
    KW'(((64'd17720 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [KW-1:0] K_RCB =
    KW'(((64'd71525 << COEF_FRAC_BITS) + 64'd5000000000) / 64'd10000000000);
  localparam logic signed [KW-1:0] K_BCR =
    KW'(((64'd40249 << COEF_FRAC_BITS) + 64'd500000000) / 64'd1000000000);

  localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  function automatic res_t round_fix(input logic signed [AW-1:0] acc);
    logic [AW-1:0]           mag;
    logic [AW-1:0]           sum;
    logic signed [RES_W-1:0] q;
    mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
    sum = mag + HALF;
    q   = $signed({1'b0, sum[AW-1:COEF_FRAC_BITS]});
    return acc[AW-1] ? -q : q;
  endfunction

  logic       color_mode;
  pix_t       pixel_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_YCBCR;
      pixel_max  <= PIXEL_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_MODE: color_mode <= cfg_data[0];
        REG_PIXEL_MAX:  pixel_max  <= cfg_data[PIX_W-1:0];
        default:        ;
      endcase
    end
  end

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // stage 1: remove the mid-scale offset
  logic [PIX_W:0]          offset;
  logic signed [CH_W-1:0]  offset_s;
  logic signed [IN_W-1:0]  s1_y;
  logic signed [CH_W-1:0]  s1_c1, s1_c2;

  assign offset   = ({1'b0, pixel_max} + 17'd1) >> 1;
  assign offset_s = $signed({{(CH_W-PIX_W-1){1'b0}}, offset});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_y  <= luma;
      s1_c1 <= CH_W'(chroma_first) - offset_s;
      s1_c2 <= CH_W'(chroma_second) - offset_s;
    end
  end

  // stage 2: coefficient products and first lifting step
  logic signed [IN_W-1:0] s2_y;
  logic signed [PW-1:0]   s2_p_rcb, s2_p_rcr, s2_p_gcb, s2_p_gcr, s2_p_bcb, s2_p_bcr;
  logic signed [20:0]     s2_t;
  logic signed [CH_W-1:0] s2_c1, s2_c2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_y     <= s1_y;
      s2_p_rcb <= s1_c1 * K_RCB;
      s2_p_rcr <= s1_c2 * K_RCR;
      s2_p_gcb <= s1_c1 * K_GCB;
      s2_p_gcr <= s1_c2 * K_GCR;
      s2_p_bcb <= s1_c1 * K_BCB;
      s2_p_bcr <= s1_c2 * K_BCR;
      s2_t     <= 21'(s1_y) - 21'(s1_c2 >>> 1);
      s2_c1    <= s1_c1;
      s2_c2    <= s1_c2;
    end
  end

  // stage 3: matrix sums and second lifting step
  logic signed [AW-1:0]   ys;
  logic signed [AW-1:0]   s3_acc_r, s3_acc_g, s3_acc_b;
  logic signed [21:0]     s3_g, s3_b;
  logic signed [CH_W-1:0] s3_c1;

  assign ys = AW'(s2_y) <<< COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_acc_r <= ys - AW'(s2_p_rcb) + AW'(s2_p_rcr);
      s3_acc_g <= ys - AW'(s2_p_gcb) - AW'(s2_p_gcr);
      s3_acc_b <= ys + AW'(s2_p_bcb) - AW'(s2_p_bcr);
      s3_g     <= 22'(s2_c2) + 22'(s2_t);
      s3_b     <= 22'(s2_t) - 22'(s2_c1 >>> 1);
      s3_c1    <= s2_c1;
    end
  end

  // stage 4: round the matrix result or finish the lifting
  res_t s4_r, s4_g, s4_b;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      if (color_mode == MODE_YCBCR) begin
        s4_r <= round_fix(s3_acc_r);
        s4_g <= round_fix(s3_acc_g);
        s4_b <= round_fix(s3_acc_b);
      end else begin
        s4_r <= RES_W'(23'(s3_b) + 23'(s3_c1));
        s4_g <= RES_W'(s3_g);
        s4_b <= RES_W'(s3_b);
      end
    end
  end

  // stage 5: saturate into the output register
  pix_t r_clip, g_clip, b_clip;

  lcrgb_clip u_clip_r (.value(s4_r), .pixel_max(pixel_max), .clipped(r_clip));
  lcrgb_clip u_clip_g (.value(s4_g), .pixel_max(pixel_max), .clipped(g_clip));
  lcrgb_clip u_clip_b (.value(s4_b), .pixel_max(pixel_max), .clipped(b_clip));

  always_ff @(posedge clk) begin
    if (rdy5) begin
      red   <= r_clip;
      green <= g_clip;
      blue  <= b_clip;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid))
    else $error("input stalled while the pipeline has a free stage");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |-> ##2 out_valid)
    else $error("accepted item did not reach the output");

endmodule

`default_nettype wire
